// ----- rtl/gjls_pkg.sv -----
// Shared types, constants and helpers for the Gauss-Jordan linear solver.
// No dependencies; every other file imports this package.
package gjls_pkg;

	localparam int DEF_MAX_N     = 16;
	localparam int DEF_FRAC_BITS = 16;
	localparam int COEF_W        = 32;
	localparam int SIZE_W        = 5;
	localparam int TOL_W         = 16;

	localparam logic [SIZE_W-1:0] SIZE_RST = 5'd4;
	localparam logic [TOL_W-1:0]  TOL_RST  = 16'd1;

	localparam logic REG_SIZE = 1'b0;
	localparam logic REG_TOL  = 1'b1;

	localparam logic [1:0] ST_UNIQUE = 2'd0;
	localparam logic [1:0] ST_INF    = 2'd1;
	localparam logic [1:0] ST_NONE   = 2'd2;

	typedef enum logic [4:0] {
		S_LOAD, S_COL, S_PSRD, S_PSCMP, S_PCHK,
		S_SWA, S_SWB, S_SWWB, S_SWWR,
		S_NRD, S_NST, S_NWT,
		S_ENXT, S_EFRD, S_EFLD, S_EYRD, S_EXRD, S_EMUL, S_ETRN, S_EWR,
		S_CRD, S_CCHK, S_OST, S_ORD, S_OLD, S_OWT
	} state_t;

	typedef enum logic [2:0] {
		WS_COEF, WS_RD, WS_A, WS_DIV, WS_MSUB
	} wsel_t;

	typedef struct packed {
		logic             we;
		wsel_t            wsel;
		logic             ld_a;
		logic             ld_b;
		logic             ld_f;
		logic             init_best;
		logic             upd_best;
		logic             mul;
		logic             trn;
		logic             div_start;
		logic             ld_out;
		logic             val_en;
		logic [TOL_W-1:0] tol;
	} cmd_t;

	typedef struct packed {
		logic better;
		logic nz;
		logic piv_small;
		logic div_done;
	} stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/gauss_jordan_linear_solver.sv -----
// Gauss-Jordan solver with partial pivoting, Q16.16, one shared divider and multiplier.
// Load: one coefficient per cycle, n(n+1) transfers. Per pivot column: search the column for
// the pivot, swap rows if needed, normalise the pivot row with the bit-serial divider, then
// eliminate the column from every other row; a skipped column runs only the search. Then
// leave the column loop, classify the rows and send one result per variable, waiting on m_tready.
// Reset: n = 4, tolerance = 1, load count cleared; matrix memory is not cleared.
module gauss_jordan_linear_solver import gjls_pkg::*; #(
	parameter int MAX_N     = DEF_MAX_N,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,     // [31:0] coefficient
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,     // [3:0] variable_index, [35:4] solution_value,
	                                       // [36] is_free, [38:37] solve_status, [39] zero
	output logic              m_tlast,     // last_result
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [TOL_W-1:0]  cfg_data
);
	localparam int AW = $clog2(MAX_N * (MAX_N + 1));

	cmd_t               cmd;
	stat_t              stat;
	logic [AW-1:0]      addr;
	logic signed [31:0] value;
	logic [3:0]         out_index;
	logic               out_free;
	logic [1:0]         out_status;

	gjls_ctrl #(.MAX_N(MAX_N), .AW(AW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_index (out_index),
		.out_free  (out_free),
		.out_status(out_status),
		.out_last  (m_tlast),
		.cmd       (cmd),
		.addr      (addr),
		.stat      (stat)
	);

	gjls_datapath #(.MAX_N(MAX_N), .FRAC_BITS(FRAC_BITS), .AW(AW)) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.addr  (addr),
		.coef  (s_tdata),
		.stat  (stat),
		.value (value)
	);

	assign m_tdata = {1'b0, out_status, out_free, value, out_index};

endmodule

// ----- rtl/gjls_div.sv -----
// Bit-serial signed fixed-point divider: (num << FRAC_BITS) / den, truncated, saturated.
// Depends on gjls_pkg for sat32 and DEF_FRAC_BITS.
module gjls_div import gjls_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);
	localparam int NUMW = 32 + FRAC_BITS;
	localparam int CW   = $clog2(NUMW + 1);

	logic [CW-1:0]   cnt_q;
	logic            done_q;
	logic            neg_q;
	logic [NUMW-1:0] dvd_q;
	logic [31:0]     dvs_q;
	logic [31:0]     rem_q;
	logic [32:0]     trial;
	logic            ge;
	logic [31:0]     num_abs;
	logic [31:0]     den_abs;
	logic signed [63:0] mag64;

	assign num_abs = num[31] ? (~num + 32'd1) : num;
	assign den_abs = den[31] ? (~den + 32'd1) : den;
	assign trial   = {rem_q, dvd_q[NUMW-1]};
	assign ge      = trial >= {1'b0, dvs_q};
	assign mag64   = 64'(dvd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(NUMW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[31] ^ den[31];
			dvd_q <= {num_abs, {FRAC_BITS{1'b0}}};
			dvs_q <= den_abs;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
			dvd_q <= {dvd_q[NUMW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = sat32(neg_q ? -mag64 : mag64);

endmodule

// ----- rtl/gjls_datapath.sv -----
// Matrix memory, magnitude compares, multiply-subtract and divider for the solver.
// Depends on gjls_pkg and gjls_div; driven by gjls_ctrl commands.
module gjls_datapath import gjls_pkg::*; #(
	parameter int MAX_N     = DEF_MAX_N,
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int AW        = $clog2(MAX_N * (MAX_N + 1))
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [AW-1:0]      addr,
	input  logic signed [31:0] coef,
	output stat_t              stat,
	output logic signed [31:0] value
);
	localparam int DEPTH = MAX_N * (MAX_N + 1);
	localparam logic signed [63:0] RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;

	logic signed [31:0] mem_q [DEPTH];
	logic signed [31:0] rd_q;
	logic signed [31:0] a_q, b_q, f_q, bestval_q, val_q;
	logic [31:0]        bestmag_q;
	logic signed [63:0] prod_q, qt_q;
	logic signed [63:0] prod_adj, diff;
	logic signed [31:0] wdata, quo;
	logic [31:0]        rd_mag;
	logic               div_done;

	gjls_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (rd_q),
		.den   (bestval_q),
		.done  (div_done),
		.quo   (quo)
	);

	assign rd_mag   = rd_q[31] ? (~rd_q + 32'd1) : rd_q;
	assign prod_adj = prod_q + (prod_q[63] ? RND : 64'sd0);
	assign diff     = 64'(a_q) - qt_q;

	always_comb begin
		case (cmd.wsel)
			WS_COEF: wdata = coef;
			WS_RD:   wdata = rd_q;
			WS_A:    wdata = a_q;
			WS_DIV:  wdata = quo;
			WS_MSUB: wdata = sat32(diff);
			default: wdata = coef;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem_q[addr] <= wdata;
		end
		rd_q <= mem_q[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_a) a_q <= rd_q;
		if (cmd.ld_b) b_q <= rd_q;
		if (cmd.ld_f) f_q <= rd_q;
		if (cmd.mul) prod_q <= f_q * b_q;
		// truncate toward zero before dropping the fraction
		if (cmd.trn) qt_q <= prod_adj >>> FRAC_BITS;
		if (cmd.init_best) begin
			bestmag_q <= '0;
			bestval_q <= '0;
		end else if (cmd.upd_best && rd_mag > bestmag_q) begin
			bestmag_q <= rd_mag;
			bestval_q <= rd_q;
		end
		if (cmd.ld_out) val_q <= cmd.val_en ? rd_q : '0;
	end

	assign stat.better    = rd_mag > bestmag_q;
	assign stat.nz        = rd_mag > 32'(cmd.tol);
	assign stat.piv_small = (bestmag_q < 32'(cmd.tol)) || (bestmag_q == '0);
	assign stat.div_done  = div_done;
	assign value          = val_q;

endmodule

// ----- rtl/gjls_ctrl.sv -----
// Sequencer for load, pivot search, swap, normalise, eliminate, classify and output.
// Depends on gjls_pkg; issues commands to gjls_datapath.
module gjls_ctrl import gjls_pkg::*; #(
	parameter int MAX_N = DEF_MAX_N,
	parameter int AW    = $clog2(MAX_N * (MAX_N + 1))
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [TOL_W-1:0]  cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        out_index,
	output logic              out_free,
	output logic [1:0]        out_status,
	output logic              out_last,
	output cmd_t              cmd,
	output logic [AW-1:0]     addr,
	input  stat_t             stat
);
	localparam int NW = $clog2(MAX_N + 1);
	localparam int CW = $clog2(MAX_N);
	localparam int PW = 2 * NW + 1;

	state_t state_q, state_d;
	logic [SIZE_W-1:0] size_q;
	logic [TOL_W-1:0]  tol_q;
	logic [AW-1:0]     load_q;
	logic [NW-1:0]     row_q, col_q, r_q, c_q, best_q;
	logic              allz_q, incons_q;
	logic [MAX_N-1:0]  flags_q;
	logic [1:0]        status_q;
	logic              outv_q, free_q, last_q;
	logic [3:0]        index_q;
	logic [1:0]        ostat_q;
	logic [NW-1:0]     n_act, arow, acol;
	logic [PW-1:0]     addr_full, total;
	logic              use_load;
	logic              load_acc, last_r, c_end;

	always_comb begin
		if (size_q == '0) begin
			n_act = NW'(1);
		end else if (32'(size_q) > MAX_N) begin
			n_act = NW'(MAX_N);
		end else begin
			n_act = NW'(size_q);
		end
	end

	assign total     = PW'(n_act) * (PW'(n_act) + PW'(1));
	assign load_acc  = in_valid && in_ready;
	assign last_r    = r_q == n_act - NW'(1);
	assign c_end     = c_q == n_act;
	assign in_ready  = state_q == S_LOAD;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD:  if (load_acc && PW'(load_q) == total - PW'(1)) state_d = S_COL;
			S_COL:   state_d = (col_q < n_act && row_q < n_act) ? S_PSRD : S_CRD;
			S_PSRD:  state_d = S_PSCMP;
			S_PSCMP: state_d = last_r ? S_PCHK : S_PSRD;
			S_PCHK: begin
				if (stat.piv_small) begin
					state_d = S_COL;
				end else begin
					state_d = (best_q != row_q) ? S_SWA : S_NRD;
				end
			end
			S_SWA:   state_d = S_SWB;
			S_SWB:   state_d = S_SWWB;
			S_SWWB:  state_d = S_SWWR;
			S_SWWR:  state_d = c_end ? S_NRD : S_SWA;
			S_NRD:   state_d = S_NST;
			S_NST:   state_d = S_NWT;
			S_NWT:   if (stat.div_done) state_d = c_end ? S_ENXT : S_NRD;
			S_ENXT: begin
				if (r_q == n_act) begin
					state_d = S_COL;
				end else if (r_q != row_q) begin
					state_d = S_EFRD;
				end
			end
			S_EFRD:  state_d = S_EFLD;
			S_EFLD:  state_d = S_EYRD;
			S_EYRD:  state_d = S_EXRD;
			S_EXRD:  state_d = S_EMUL;
			S_EMUL:  state_d = S_ETRN;
			S_ETRN:  state_d = S_EWR;
			S_EWR:   state_d = c_end ? S_ENXT : S_EYRD;
			S_CRD:   state_d = S_CCHK;
			S_CCHK:  state_d = (c_end && last_r) ? S_OST : S_CRD;
			S_OST:   state_d = S_ORD;
			S_ORD:   state_d = S_OLD;
			S_OLD:   state_d = S_OWT;
			S_OWT:   if (out_ready) state_d = last_r ? S_LOAD : S_ORD;
			default: state_d = S_LOAD;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.wsel = WS_COEF;
		cmd.tol  = tol_q;
		arow     = '0;
		acol     = '0;
		use_load = 1'b0;
		case (state_q)
			S_LOAD: begin
				use_load = 1'b1;
				cmd.we   = load_acc;
			end
			S_COL:   cmd.init_best = 1'b1;
			S_PSRD: begin
				arow = r_q;
				acol = col_q;
			end
			S_PSCMP: cmd.upd_best = 1'b1;
			S_SWA: begin
				arow = best_q;
				acol = c_q;
			end
			S_SWB: begin
				arow     = row_q;
				acol     = c_q;
				cmd.ld_a = 1'b1;
			end
			S_SWWB: begin
				arow     = best_q;
				acol     = c_q;
				cmd.we   = 1'b1;
				cmd.wsel = WS_RD;
			end
			S_SWWR: begin
				arow     = row_q;
				acol     = c_q;
				cmd.we   = 1'b1;
				cmd.wsel = WS_A;
			end
			S_NRD: begin
				arow = row_q;
				acol = c_q;
			end
			S_NST:   cmd.div_start = 1'b1;
			S_NWT: begin
				arow     = row_q;
				acol     = c_q;
				cmd.we   = stat.div_done;
				cmd.wsel = WS_DIV;
			end
			S_EFRD: begin
				arow = r_q;
				acol = col_q;
			end
			S_EFLD:  cmd.ld_f = 1'b1;
			S_EYRD: begin
				arow = row_q;
				acol = c_q;
			end
			S_EXRD: begin
				arow     = r_q;
				acol     = c_q;
				cmd.ld_b = 1'b1;
			end
			S_EMUL: begin
				cmd.ld_a = 1'b1;
				cmd.mul  = 1'b1;
			end
			S_ETRN:  cmd.trn = 1'b1;
			S_EWR: begin
				arow     = r_q;
				acol     = c_q;
				cmd.we   = 1'b1;
				cmd.wsel = WS_MSUB;
			end
			S_CRD: begin
				arow = r_q;
				acol = c_q;
			end
			S_ORD: begin
				arow = r_q;
				acol = n_act;
			end
			S_OLD: begin
				cmd.ld_out = 1'b1;
				cmd.val_en = status_q == ST_UNIQUE;
			end
			default: cmd.tol = tol_q;
		endcase
	end

	assign addr_full = PW'(arow) * (PW'(n_act) + PW'(1)) + PW'(acol);
	assign addr      = use_load ? load_q : AW'(addr_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			size_q   <= SIZE_RST;
			tol_q    <= TOL_RST;
			load_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
			r_q      <= '0;
			c_q      <= '0;
			best_q   <= '0;
			allz_q   <= 1'b1;
			incons_q <= 1'b0;
			flags_q  <= '0;
			status_q <= ST_UNIQUE;
			outv_q   <= 1'b0;
			free_q   <= 1'b0;
			last_q   <= 1'b0;
			index_q  <= '0;
			ostat_q  <= ST_UNIQUE;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_LOAD: begin
					if (load_acc) begin
						if (PW'(load_q) == total - PW'(1)) begin
							load_q <= '0;
							row_q  <= '0;
							col_q  <= '0;
						end else begin
							load_q <= load_q + 1'b1;
						end
					end
				end
				S_COL: begin
					if (col_q < n_act && row_q < n_act) begin
						r_q    <= row_q;
						best_q <= row_q;
					end else begin
						r_q      <= '0;
						c_q      <= '0;
						allz_q   <= 1'b1;
						flags_q  <= '0;
						incons_q <= 1'b0;
					end
				end
				S_PSCMP: begin
					if (stat.better) best_q <= r_q;
					if (!last_r) r_q <= r_q + 1'b1;
				end
				S_PCHK: begin
					if (stat.piv_small) begin
						col_q <= col_q + 1'b1;
					end else begin
						c_q <= '0;
					end
				end
				S_SWWR: c_q <= c_end ? '0 : c_q + 1'b1;
				S_NWT: begin
					if (stat.div_done) begin
						if (c_end) begin
							c_q <= '0;
							r_q <= '0;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
				end
				S_ENXT: begin
					if (r_q == n_act) begin
						row_q <= row_q + 1'b1;
						col_q <= col_q + 1'b1;
					end else if (r_q == row_q) begin
						r_q <= r_q + 1'b1;
					end else begin
						c_q <= '0;
					end
				end
				S_EWR: begin
					if (c_end) begin
						r_q <= r_q + 1'b1;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				S_CCHK: begin
					if (!c_end) begin
						// first entry above tolerance marks the leading column
						if (stat.nz && allz_q) begin
							flags_q[c_q[CW-1:0]] <= 1'b1;
							allz_q               <= 1'b0;
						end
						c_q <= c_q + 1'b1;
					end else begin
						if (allz_q && stat.nz) incons_q <= 1'b1;
						allz_q <= 1'b1;
						c_q    <= '0;
						r_q    <= last_r ? '0 : r_q + 1'b1;
					end
				end
				S_OST: begin
					if (incons_q) begin
						status_q <= ST_NONE;
					end else if (row_q < n_act) begin
						status_q <= ST_INF;
					end else begin
						status_q <= ST_UNIQUE;
					end
				end
				S_OLD: begin
					outv_q  <= 1'b1;
					index_q <= 4'(r_q);
					free_q  <= (status_q == ST_INF) && !flags_q[r_q[CW-1:0]];
					ostat_q <= status_q;
					last_q  <= last_r;
				end
				S_OWT: begin
					if (out_ready) begin
						outv_q <= 1'b0;
						if (!last_r) r_q <= r_q + 1'b1;
					end
				end
				default: row_q <= row_q;
			endcase
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SIZE) begin
					size_q <= cfg_data[SIZE_W-1:0];
					load_q <= '0;
				end else begin
					tol_q <= cfg_data;
				end
			end
		end
	end

	assign out_valid  = outv_q;
	assign out_index  = index_q;
	assign out_free   = free_q;
	assign out_status = ostat_q;
	assign out_last   = last_q;

endmodule
